@@ design/salc_pkg.sv @@
// Shared constants, types and helpers for the set-associative LRU cache lookup.
// No dependencies; every other design file imports this package.
package salc_pkg;

    localparam int SETS             = 64;
    localparam int WAYS             = 8;
    localparam int LINE_OFFSET_BITS = 6;
    localparam int ADDRESS_BITS     = 36;
    localparam int CNT_BITS         = 32;

    localparam int SET_BITS = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_BITS = $clog2(WAYS);
    localparam int TAG_BITS = ADDRESS_BITS - LINE_OFFSET_BITS - SET_BITS;

    typedef logic [ADDRESS_BITS-1:0]            t_addr;
    typedef logic [SET_BITS-1:0]                t_set;
    typedef logic [TAG_BITS-1:0]                t_tag;
    typedef logic [WAY_BITS-1:0]                t_way;
    typedef logic [WAYS-1:0]                    t_valid;
    typedef logic [CNT_BITS-1:0]                t_cnt;
    // lru[0] is the least recently used way, lru[WAYS-1] the most recent
    typedef logic [WAYS-1:0][WAY_BITS-1:0]      t_lru;
    typedef logic [WAYS-1:0][TAG_BITS-1:0]      t_tags;

    typedef struct packed {
        t_valid valid;
        t_lru   lru;
        t_tags  tags;
    } t_row;

    // commands from the controller to the datapath
    typedef struct packed {
        logic rd_en;   // latch address, read the set row
        logic upd;     // resolve lookup, write back, load result
    } t_cmd;

    function automatic t_lru lru_reset_order();
        t_lru order;
        for (int k = 0; k < WAYS; k++) begin
            order[k] = WAY_BITS'(k);
        end
        return order;
    endfunction

endpackage

@@ design/salc_in_if.sv @@
// Address input channel: valid/ready handshake with one address per word.
// Depends on salc_pkg.
interface salc_in_if import salc_pkg::*; ();
    logic  valid;
    logic  ready;
    t_addr address;

    modport source (output valid, output address, input ready);
    modport sink   (input valid, input address, output ready);
endinterface

@@ design/salc_out_if.sv @@
// Lookup result channel: valid/ready handshake with one result per word.
// Depends on salc_pkg.
interface salc_out_if import salc_pkg::*; ();
    logic valid;
    logic ready;
    logic hit;
    t_way way;
    logic evicted;
    t_cnt hit_total;
    t_cnt miss_total;

    modport source (output valid, output hit, output way, output evicted,
                    output hit_total, output miss_total, input ready);
    modport sink   (input valid, input hit, input way, input evicted,
                    input hit_total, input miss_total, output ready);
endinterface

@@ design/salc_ctrl.sv @@
// Controller: two-state sequencer that reads a set, then resolves it once the
// output register is free. Depends on salc_pkg.
module salc_ctrl import salc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd
);

    localparam logic [0:0] ST_IDLE = 1'b0;
    localparam logic [0:0] ST_CMP  = 1'b1;

    logic [0:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       slot_free;

    assign slot_free  = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state   = r_state;
        o_cmd     = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = ST_CMP;
                end
            end
            ST_CMP: begin
                if (slot_free) begin
                    o_cmd.upd = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.upd) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ design/salc_dpath.sv @@
// Datapath: set row memory (valid bits, tags, LRU order), per-set written flags,
// way compare, replacement choice, LRU update and saturating counters. Depends on salc_pkg.
module salc_dpath import salc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cmd  i_cmd,
    input  t_addr i_address,
    output logic  o_hit,
    output t_way  o_way,
    output logic  o_evicted,
    output t_cnt  o_hit_total,
    output t_cnt  o_miss_total
);

    t_row            r_mem [SETS];
    t_row            r_rd_row;
    logic [SETS-1:0] r_touched;
    logic            r_rd_touched;
    t_set            r_set;
    t_tag            r_tag;
    t_cnt            r_hits, r_misses;
    logic            r_hit, r_evicted;
    t_way            r_way;

    t_set   in_set;
    t_tag   in_tag;
    t_valid cur_valid;
    t_lru   cur_lru;
    logic   hit, empty_found, evict;
    t_way   hit_way, empty_way, way;
    t_way   pos;
    t_lru   n_lru;
    t_tags  n_tags;
    t_valid n_valid;
    t_row   n_row;

    assign in_set = i_address[LINE_OFFSET_BITS +: SET_BITS];
    assign in_tag = i_address[LINE_OFFSET_BITS + SET_BITS +: TAG_BITS];

    // row memory: one read on accept, one write on resolve
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_row     <= r_mem[in_set];
            r_rd_touched <= r_touched[in_set];
            r_set        <= in_set;
            r_tag        <= in_tag;
        end
        if (i_cmd.upd) begin
            r_mem[r_set] <= n_row;
        end
    end

    // a set never written since reset reads as empty with the reset LRU order
    assign cur_valid = r_rd_touched ? r_rd_row.valid : '0;
    assign cur_lru   = r_rd_touched ? r_rd_row.lru : lru_reset_order();

    always_comb begin
        hit         = 1'b0;
        hit_way     = '0;
        empty_found = 1'b0;
        empty_way   = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (!hit && cur_valid[w] && (r_rd_row.tags[w] == r_tag)) begin
                hit     = 1'b1;
                hit_way = WAY_BITS'(w);
            end
            if (!empty_found && !cur_valid[w]) begin
                empty_found = 1'b1;
                empty_way   = WAY_BITS'(w);
            end
        end
        evict = !hit && !empty_found;
        if (hit) begin
            way = hit_way;
        end else if (empty_found) begin
            way = empty_way;
        end else begin
            way = cur_lru[0];
        end
    end

    // move the used way to the most recent end
    always_comb begin
        pos = '0;
        for (int k = 0; k < WAYS; k++) begin
            if (cur_lru[k] == way) begin
                pos = WAY_BITS'(k);
            end
        end
        for (int k = 0; k < WAYS - 1; k++) begin
            if (WAY_BITS'(k) >= pos) begin
                n_lru[k] = cur_lru[k + 1];
            end else begin
                n_lru[k] = cur_lru[k];
            end
        end
        n_lru[WAYS-1] = way;
        n_tags = r_rd_row.tags;
        if (!hit) begin
            n_tags[way] = r_tag;
        end
        n_valid      = cur_valid;
        n_valid[way] = 1'b1;
        n_row.valid  = n_valid;
        n_row.lru    = n_lru;
        n_row.tags   = n_tags;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_touched <= '0;
            r_hits    <= '0;
            r_misses  <= '0;
        end else if (i_cmd.upd) begin
            r_touched[r_set] <= 1'b1;
            if (hit && (r_hits != '1)) begin
                r_hits <= r_hits + 1'b1;
            end
            if (!hit && (r_misses != '1)) begin
                r_misses <= r_misses + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            r_hit     <= hit;
            r_way     <= way;
            r_evicted <= evict;
        end
    end

    assign o_hit        = r_hit;
    assign o_way        = r_way;
    assign o_evicted    = r_evicted;
    assign o_hit_total  = r_hits;
    assign o_miss_total = r_misses;

endmodule

@@ design/set_assoc_lru_cache_lookup_top.sv @@
// Eight-way set-associative cache lookup with true LRU replacement. Each
// address word first has its set row (valid bits, tags and LRU order) read
// from the single-port row memory, then has all ways compared and the row
// written back; a new address is taken only once the previous one has been
// resolved, and the resolve step waits while the previous result is still
// held. A per-set written flag clears at reset and makes an untouched set read
// as empty, so no clearing pass is needed. Depends on salc_pkg, the channel
// interfaces, salc_ctrl and salc_dpath.
module set_assoc_lru_cache_lookup_top import salc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    salc_in_if.sink           i_in,
    salc_out_if.source        o_out
);

    t_cmd cmd;

    salc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd)
    );

    salc_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_address    (i_in.address),
        .o_hit        (o_out.hit),
        .o_way        (o_out.way),
        .o_evicted    (o_out.evicted),
        .o_hit_total  (o_out.hit_total),
        .o_miss_total (o_out.miss_total)
    );

    // an accepted word blocks the input while it waits to be resolved
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input accepted during resolve");

    // a hit never evicts
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.hit && o_out.evicted))
        else $error("hit reported with eviction");

    // datapath only resolves when the controller is in its resolve state
    a_upd_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.upd |-> !i_in.ready)
        else $error("update outside resolve state");

    // counters never move backward once a result has been shown
    a_counts_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |=> (o_out.hit_total >= $past(o_out.hit_total)) &&
                        (o_out.miss_total >= $past(o_out.miss_total)))
        else $error("counter decreased");

endmodule
